/* hdl/dffv_pkg.sv */
// ----------------------------------------------------------------------------
// dffv_pkg
// shared constants, codes and the result record of the frame validator
// ----------------------------------------------------------------------------
package dffv_pkg;

	localparam int LENGTH_WIDTH = 12;
	localparam int OFF_W        = 13;
	localparam int CFG_W        = 12;
	localparam int CMP_W        = (LENGTH_WIDTH + 1 > OFF_W) ? LENGTH_WIDTH + 1 : OFF_W;

	localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(2048);

	localparam logic [7:0] BYTE_FF = 8'hff;
	localparam logic [7:0] BYTE_EF = 8'hef;
	localparam logic [7:0] BYTE_FD = 8'hfd;

	localparam logic [1:0] FUNC_DATA  = 2'd0;
	localparam logic [1:0] FUNC_OPEN  = 2'd1;
	localparam logic [1:0] FUNC_CLOSE = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_HDR   = 3'd1;
	localparam logic [2:0] ST_TOO_LARGE = 3'd2;
	localparam logic [2:0] ST_BAD_START = 3'd3;
	localparam logic [2:0] ST_BAD_TAIL  = 3'd4;
	localparam logic [2:0] ST_TOO_SHORT = 3'd5;

	typedef struct packed {
		logic [2:0]  status;
		logic        format_b;
		logic [12:0] frame_length;
		logic        is_heartbeat;
		logic [7:0]  total_frames;
		logic [7:0]  frame_number;
	} dffv_result_t;

endpackage

/* hdl/dual_format_frame_validator.sv */
// ----------------------------------------------------------------------------
// dual_format_frame_validator
// checks session byte streams framed in either of two header formats
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle when the output is not stalled. A beat sits
// in an input register while the session state is checked and updated,
// and any result lands in the output register, from which it is offered on
// the output. Beats that produce no result never wait on the output side;
// a beat that produces a result waits only while the output register still
// holds an untaken result.
module dual_format_frame_validator import dffv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,     // length limit
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,       // data_byte
	input  logic [1:0]       s_tuser,       // func
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,       // format_b, frame_length, is_heartbeat,
	                                        // total_frames, frame_number, zero pad
	output logic [2:0]       m_tuser        // status
);

	logic [CFG_W-1:0] max_len_q;
	logic             valid_s1;
	logic [1:0]       func_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	dffv_result_t     out_q;

	logic             res_valid;
	dffv_result_t     res;
	logic             out_free;
	logic             advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	dffv_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.func         (func_s1),
		.data_byte    (byte_s1),
		.len_limit    (max_len_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {1'b0, out_q.frame_number, out_q.total_frames, out_q.is_heartbeat,
		out_q.frame_length, out_q.format_b};

endmodule

/* hdl/dffv_parser.sv */
// ----------------------------------------------------------------------------
// dffv_parser
// session state and per-beat header, length, start-byte and tail checks
// ----------------------------------------------------------------------------
module dffv_parser import dffv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          func,
	input  logic [7:0]          data_byte,
	input  logic [CFG_W-1:0]    len_limit,
	output logic                res_valid,
	output dffv_result_t        res
);

	typedef enum logic [1:0] {
		MODE_DETECT,
		MODE_A,
		MODE_B,
		MODE_HALT
	} mode_t;

	mode_t                   mode_q, mode_d;
	logic [OFF_W-1:0]        off_q, off_d;
	logic [LENGTH_WIDTH-1:0] len_q, len_d;
	logic                    ovf_q, ovf_d;
	logic [7:0]              prev_q, prev_d;
	logic [7:0]              cnt_q, cnt_d;
	logic [7:0]              idx_q, idx_d;

	always_comb begin
		logic                    fail;
		logic                    done;
		logic [2:0]              st;
		logic [12:0]             flen;
		logic                    hb;
		logic [LENGTH_WIDTH-1:0] len_hi;
		logic                    ovf_hi;
		logic [CMP_W-1:0]        endoff;
		logic [CMP_W-1:0]        off_x;
		logic                    too_big;

		mode_d = mode_q;
		off_d  = off_q;
		len_d  = len_q;
		ovf_d  = ovf_q;
		prev_d = prev_q;
		cnt_d  = cnt_q;
		idx_d  = idx_q;
		fail   = 1'b0;
		done   = 1'b0;
		st     = ST_OK;
		flen   = '0;
		hb     = 1'b0;
		res_valid = 1'b0;

		// high length byte merged into the length
		ovf_hi = ((data_byte >> (LENGTH_WIDTH - 8)) != 8'd0);
		len_hi = len_q | (LENGTH_WIDTH'(data_byte) << 8);
		endoff = CMP_W'(len_q) + CMP_W'(7);
		off_x  = CMP_W'(off_q);
		too_big = 1'b0;

		case (func)
			FUNC_OPEN: begin
				mode_d = MODE_DETECT;
				off_d  = '0;
				len_d  = '0;
				ovf_d  = 1'b0;
				prev_d = '0;
				cnt_d  = '0;
				idx_d  = '0;
			end
			FUNC_CLOSE: begin
				if (mode_q != MODE_HALT && off_q != '0) begin
					res_valid = 1'b1;
					st = ST_TOO_SHORT;
				end
				mode_d = MODE_HALT;
				off_d  = '0;
			end
			FUNC_DATA: begin
				if (mode_q != MODE_HALT) begin
					prev_d = data_byte;
					off_d  = off_q + OFF_W'(1);
					case (mode_q)
						MODE_DETECT: begin
							if (off_q == OFF_W'(0)) begin
								if (data_byte != BYTE_FF && data_byte != BYTE_EF) begin
									fail = 1'b1;
									st = ST_BAD_HDR;
								end
							end else if (off_q == OFF_W'(1)) begin
								if (prev_q == BYTE_EF && data_byte == BYTE_EF) begin
									mode_d = MODE_B;
								end else if (!(prev_q == BYTE_FF && data_byte == BYTE_FF)) begin
									fail = 1'b1;
									st = ST_BAD_HDR;
								end
							end else begin
								if (data_byte != BYTE_FF) begin
									fail = 1'b1;
									st = ST_BAD_HDR;
								end else if (off_q >= OFF_W'(3)) begin
									mode_d = MODE_A;
								end
							end
						end
						MODE_A: begin
							if (off_q < OFF_W'(4)) begin
								// header bytes of later frames pass unchecked
							end else if (off_q == OFF_W'(4)) begin
								len_d = LENGTH_WIDTH'(data_byte);
								ovf_d = 1'b0;
							end else if (off_q == OFF_W'(5)) begin
								if (ovf_hi)
									ovf_d = 1'b1;
								else
									len_d = len_hi;
							end else if (off_q <= OFF_W'(7)) begin
								if (data_byte != 8'd0)
									ovf_d = 1'b1;
								if (off_q == OFF_W'(7)) begin
									too_big = ovf_q || (data_byte != 8'd0) ||
										(CMP_W'(len_q) > CMP_W'(len_limit));
									if (too_big) begin
										fail = 1'b1;
										st = ST_TOO_LARGE;
									end else if (len_q == '0) begin
										fail = 1'b1;
										st = ST_TOO_SHORT;
									end else if (len_q == LENGTH_WIDTH'(1)) begin
										done = 1'b1;
										flen = 13'd8;
										hb   = 1'b1;
									end
								end
							end else if ((off_q == OFF_W'(8) || off_q == OFF_W'(9)) &&
									data_byte != BYTE_EF) begin
								fail = 1'b1;
								st = ST_BAD_START;
							end else if (off_x >= endoff) begin
								if (data_byte != BYTE_FD) begin
									fail = 1'b1;
									st = ST_BAD_TAIL;
								end else begin
									done = 1'b1;
									flen = 13'(CMP_W'(len_q) + CMP_W'(8));
								end
							end
						end
						MODE_B: begin
							if (off_q < OFF_W'(2)) begin
								// header bytes of later frames pass unchecked
							end else if (off_q == OFF_W'(2)) begin
								cnt_d = data_byte;
							end else if (off_q == OFF_W'(3)) begin
								idx_d = data_byte;
							end else if (off_q == OFF_W'(4)) begin
								len_d = LENGTH_WIDTH'(data_byte);
								ovf_d = 1'b0;
							end else if (off_q == OFF_W'(5)) begin
								if (ovf_hi)
									ovf_d = 1'b1;
								else
									len_d = len_hi;
								too_big = ovf_q || ovf_hi ||
									(CMP_W'(len_hi) > CMP_W'(len_limit));
								if (too_big) begin
									fail = 1'b1;
									st = ST_TOO_LARGE;
								end
							end else if (off_x >= endoff) begin
								if (prev_q != BYTE_FD || data_byte != BYTE_FD) begin
									fail = 1'b1;
									st = ST_BAD_TAIL;
								end else begin
									done = 1'b1;
									flen = 13'(CMP_W'(len_q) + CMP_W'(8));
								end
							end
						end
						default: begin
						end
					endcase
					if (fail) begin
						res_valid = 1'b1;
						mode_d = MODE_HALT;
						off_d  = '0;
					end else if (done) begin
						res_valid = 1'b1;
						off_d  = '0;
					end
				end
			end
			default: begin
			end
		endcase

		res.status       = st;
		res.format_b     = (mode_q == MODE_B);
		res.frame_length = (st == ST_OK) ? flen : 13'd0;
		res.is_heartbeat = (st == ST_OK) && hb;
		res.total_frames = (st == ST_OK && mode_q == MODE_B) ? cnt_q : 8'd0;
		res.frame_number = (st == ST_OK && mode_q == MODE_B) ? idx_q : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DETECT;
			off_q  <= '0;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			prev_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			off_q  <= off_d;
			len_q  <= len_d;
			ovf_q  <= ovf_d;
			prev_q <= prev_d;
			cnt_q  <= cnt_d;
			idx_q  <= idx_d;
		end
	end

endmodule
